FILE: hdl/bmpdec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_pkg: shared types and constants for the 24-bit BMP stream decoder
// Header field layout, fixed header values, result kinds and result record.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

    // Byte count of file header plus info header
    localparam int HEADER_BYTES = 54;
    localparam int NUM_FIELDS   = 15;

    // First byte of each header field, plus the end marker
    localparam logic [5:0] FIELD_START [0:NUM_FIELDS] = '{
        6'd0,  6'd2,  6'd6,  6'd10, 6'd14, 6'd18, 6'd22, 6'd26,
        6'd28, 6'd30, 6'd34, 6'd38, 6'd42, 6'd46, 6'd50, 6'd54
    };

    // Header fields that get checked
    localparam logic [3:0] FLD_SIGNATURE        = 4'd0;
    localparam logic [3:0] FLD_WIDTH            = 4'd5;
    localparam logic [3:0] FLD_HEIGHT           = 4'd6;
    localparam logic [3:0] FLD_PLANES           = 4'd7;
    localparam logic [3:0] FLD_BIT_COUNT        = 4'd8;
    localparam logic [3:0] FLD_COMPRESSION      = 4'd9;
    localparam logic [3:0] FLD_X_PPM            = 4'd11;
    localparam logic [3:0] FLD_Y_PPM            = 4'd12;
    localparam logic [3:0] FLD_COLORS_USED      = 4'd13;
    localparam logic [3:0] FLD_COLORS_IMPORTANT = 4'd14;

    // Required header values
    localparam logic [31:0] SIGNATURE_BM      = 32'h0000_4D42;
    localparam logic [31:0] PLANES_ONE        = 32'd1;
    localparam logic [31:0] COLOR_DEPTH_24    = 32'd24;
    localparam logic [31:0] COMPRESSION_NONE  = 32'd0;
    localparam logic [31:0] PELS_PER_METER    = 32'd11811;
    localparam logic [31:0] COLORS_USED_NONE  = 32'd0;
    localparam logic [31:0] COLORS_IMPORTANT  = 32'h0100_0000;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PIXEL  = 2'd2
    } result_kind_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [11:0]  column;
        logic [11:0]  row;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic         last_pixel;
        logic [12:0]  hdr_width;
        logic [12:0]  hdr_height;
    } result_t;

    // Header field that holds a given header byte
    function automatic logic [3:0] field_of(input logic [5:0] idx);
        logic [3:0] id;
        id = 4'd0;
        for (int i = 1; i < NUM_FIELDS; i++)
        begin
            if (idx >= FIELD_START[i])
                id = 4'(i);
        end
        return id;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bmpdec_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_byte_if: file byte channel
// Valid/ready channel carrying one file byte and its start-of-file mark.
// ----------------------------------------------------------------------------
interface bmpdec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

FILE: hdl/bmpdec_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_result_if: decoder result channel
// Valid/ready channel carrying header verdicts and decoded pixels.
// ----------------------------------------------------------------------------
interface bmpdec_result_if import bmpdec_pkg::*; ();
    logic         valid;
    logic         ready;
    result_kind_t result_kind;
    logic [11:0]  column;
    logic [11:0]  row;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         last_pixel;
    logic [12:0]  hdr_width;
    logic [12:0]  hdr_height;

    modport source (output valid, output result_kind, output column, output row,
                    output red, output green, output blue, output last_pixel,
                    output hdr_width, output hdr_height, input ready);
    modport sink   (input valid, input result_kind, input column, input row,
                    input red, input green, input blue, input last_pixel,
                    input hdr_width, input hdr_height, output ready);
endinterface

`default_nettype wire

FILE: hdl/bmp24_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_decoder: streaming decoder for uncompressed 24-bit BMP files
// Parses and checks the 54-byte header, then turns BGR triples into pixels
// with column and row, bottom row first, skipping row padding.
// ----------------------------------------------------------------------------
//  Port     | Dir  | Carries
//  ---------+------+----------------------------------------------------
//  bytes    | in   | data_byte, start_of_file (one file byte a request)
//  results  | out  | accept/reject verdict or one pixel a request
//
//  One byte is taken every cycle while ready is high; each byte updates the
//  parse state in the cycle it is taken, and a result is registered in the
//  output register, or in the skid register while the output register is
//  held. This two-entry output buffer keeps the byte side running while a
//  result waits; ready drops only with both full. Reset puts the parser in
//  the halted phase; bytes are ignored until a start-of-file mark.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
    import bmpdec_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    bmpdec_byte_if.sink    bytes,
    bmpdec_result_if.source results
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    typedef enum logic [1:0] {
        PH_HALTED,
        PH_HEADER,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [5:0]      header_index_reg, header_index_next;
    logic [31:0]     field_assembly_reg, field_assembly_next;
    logic            checks_passed_reg, checks_passed_next;
    logic [DIM_W-1:0] stored_width_reg, stored_width_next;
    logic [DIM_W-1:0] stored_height_reg, stored_height_next;
    logic [DIM_W-1:0] column_count_reg, column_count_next;
    logic [DIM_W-1:0] row_count_reg, row_count_next;
    logic [1:0]      channel_index_reg, channel_index_next;
    logic [7:0]      blue_hold_reg, blue_hold_next;
    logic [7:0]      green_hold_reg, green_hold_next;
    logic [1:0]      pad_left_reg, pad_left_next;

    logic            out_valid_reg, out_valid_next;
    result_t         out_data_reg, out_data_next;
    logic            skid_valid_reg, skid_valid_next;
    result_t         skid_data_reg, skid_data_next;

    logic            accept;
    logic            out_take;
    logic            res_valid;
    result_t         res_data;

    // Effective state after a start-of-file restart
    phase_t          eff_phase;
    logic [5:0]      eff_index;
    logic [31:0]     eff_assembly;
    logic            eff_checks;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;

    // Header field decode
    logic [3:0]      fld_id;
    logic [5:0]      fld_pos;
    logic            fld_end;
    logic [31:0]     asm_value;
    logic            dim_ok;
    logic            fld_ok;
    logic            checks_now;

    // Pixel bookkeeping
    logic [DIM_W:0]  col_plus_one;
    logic [31:0]     width_wide;
    logic [31:0]     col_wide;
    logic [31:0]     row_wide;

    assign accept   = bytes.valid && bytes.ready;
    assign out_take = out_valid_reg && results.ready;

    // Apply restart on a start mark
    always_comb
    begin
        if (bytes.start_of_file)
        begin
            eff_phase    = PH_HEADER;
            eff_index    = '0;
            eff_assembly = '0;
            eff_checks   = 1'b1;
            eff_width    = '0;
            eff_height   = '0;
        end
        else
        begin
            eff_phase    = phase_reg;
            eff_index    = header_index_reg;
            eff_assembly = field_assembly_reg;
            eff_checks   = checks_passed_reg;
            eff_width    = stored_width_reg;
            eff_height   = stored_height_reg;
        end
    end

    // Assemble the current header field and check it on its last byte
    always_comb
    begin
        fld_id    = field_of(eff_index);
        fld_pos   = eff_index - FIELD_START[fld_id];
        fld_end   = (eff_index + 6'd1) == FIELD_START[fld_id + 4'd1];
        asm_value = ((fld_pos == 6'd0) ? 32'd0 : eff_assembly)
                  | (32'(bytes.data_byte) << {fld_pos[1:0], 3'b000});
        dim_ok    = (asm_value >= 32'd1) && (asm_value <= 32'(MAX_DIMENSION));
        unique case (fld_id)
            FLD_SIGNATURE:        fld_ok = asm_value == SIGNATURE_BM;
            FLD_WIDTH:            fld_ok = dim_ok;
            FLD_HEIGHT:           fld_ok = dim_ok;
            FLD_PLANES:           fld_ok = asm_value == PLANES_ONE;
            FLD_BIT_COUNT:        fld_ok = asm_value == COLOR_DEPTH_24;
            FLD_COMPRESSION:      fld_ok = asm_value == COMPRESSION_NONE;
            FLD_X_PPM:            fld_ok = asm_value == PELS_PER_METER;
            FLD_Y_PPM:            fld_ok = asm_value == PELS_PER_METER;
            FLD_COLORS_USED:      fld_ok = asm_value == COLORS_USED_NONE;
            FLD_COLORS_IMPORTANT: fld_ok = asm_value == COLORS_IMPORTANT;
            default:              fld_ok = 1'b1;
        endcase
        checks_now = eff_checks && !(fld_end && !fld_ok);
    end

    assign width_wide   = 32'(stored_width_reg);
    assign col_wide     = 32'(column_count_reg);
    assign row_wide     = 32'(row_count_reg);
    assign col_plus_one = {1'b0, column_count_reg} + {{DIM_W{1'b0}}, 1'b1};

    // Advance the parser for one accepted byte
    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        field_assembly_next = field_assembly_reg;
        checks_passed_next  = checks_passed_reg;
        stored_width_next   = stored_width_reg;
        stored_height_next  = stored_height_reg;
        column_count_next   = column_count_reg;
        row_count_next      = row_count_reg;
        channel_index_next  = channel_index_reg;
        blue_hold_next      = blue_hold_reg;
        green_hold_next     = green_hold_reg;
        pad_left_next       = pad_left_reg;
        res_valid           = 1'b0;
        res_data            = '0;

        if (accept)
        begin
            phase_next          = eff_phase;
            header_index_next   = eff_index;
            field_assembly_next = eff_assembly;
            checks_passed_next  = eff_checks;
            stored_width_next   = eff_width;
            stored_height_next  = eff_height;

            unique case (eff_phase)
                PH_HEADER:
                begin
                    field_assembly_next = asm_value;
                    checks_passed_next  = checks_now;
                    header_index_next   = eff_index + 6'd1;
                    if (fld_end && fld_id == FLD_WIDTH)
                        stored_width_next = dim_ok ? asm_value[DIM_W-1:0] : '0;
                    if (fld_end && fld_id == FLD_HEIGHT)
                        stored_height_next = dim_ok ? asm_value[DIM_W-1:0] : '0;
                    // Last header byte: give the verdict
                    if (eff_index == 6'(HEADER_BYTES - 1))
                    begin
                        res_valid = 1'b1;
                        if (checks_now)
                        begin
                            res_data.result_kind = KIND_ACCEPT;
                            res_data.hdr_width   = 13'(32'(stored_width_next));
                            res_data.hdr_height  = 13'(32'(stored_height_next));
                            phase_next         = PH_PIXELS;
                            column_count_next  = '0;
                            row_count_next     = stored_height_next - DIM_W'(1);
                            channel_index_next = 2'd0;
                            pad_left_next      = 2'd0;
                        end
                        else
                        begin
                            res_data.result_kind = KIND_REJECT;
                            phase_next           = PH_HALTED;
                        end
                    end
                end
                PH_PIXELS:
                begin
                    priority if (pad_left_reg != 2'd0)
                    begin
                        // Drop a row padding byte
                        pad_left_next = pad_left_reg - 2'd1;
                    end
                    else if (channel_index_reg == 2'd0)
                    begin
                        blue_hold_next     = bytes.data_byte;
                        channel_index_next = 2'd1;
                    end
                    else if (channel_index_reg == 2'd1)
                    begin
                        green_hold_next    = bytes.data_byte;
                        channel_index_next = 2'd2;
                    end
                    else
                    begin
                        channel_index_next   = 2'd0;
                        res_valid            = 1'b1;
                        res_data.result_kind = KIND_PIXEL;
                        res_data.column      = col_wide[11:0];
                        res_data.row         = row_wide[11:0];
                        res_data.red         = bytes.data_byte;
                        res_data.green       = green_hold_reg;
                        res_data.blue        = blue_hold_reg;
                        // End of row: wrap column, step row up the image
                        if (col_plus_one >= {1'b0, stored_width_reg})
                        begin
                            column_count_next = '0;
                            if (row_count_reg == '0)
                            begin
                                res_data.last_pixel = 1'b1;
                                phase_next          = PH_DONE;
                            end
                            else
                            begin
                                row_count_next = row_count_reg - DIM_W'(1);
                                pad_left_next  = width_wide[1:0];
                            end
                        end
                        else
                        begin
                            column_count_next = col_plus_one[DIM_W-1:0];
                        end
                    end
                end
                default:
                begin
                    // Halted or done: ignore the byte
                end
            endcase
        end
    end

    // Route results through the output register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res_data;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    // Hold control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HALTED;
            header_index_reg   <= '0;
            checks_passed_reg  <= 1'b1;
            stored_width_reg   <= '0;
            stored_height_reg  <= '0;
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            channel_index_reg  <= '0;
            pad_left_reg       <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            checks_passed_reg  <= checks_passed_next;
            stored_width_reg   <= stored_width_next;
            stored_height_reg  <= stored_height_next;
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            channel_index_reg  <= channel_index_next;
            pad_left_reg       <= pad_left_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        field_assembly_reg <= field_assembly_next;
        blue_hold_reg      <= blue_hold_next;
        green_hold_reg     <= green_hold_next;
        out_data_reg       <= out_data_next;
        skid_data_reg      <= skid_data_next;
    end

    assign bytes.ready          = !skid_valid_reg;
    assign results.valid        = out_valid_reg;
    assign results.result_kind  = out_data_reg.result_kind;
    assign results.column       = out_data_reg.column;
    assign results.row          = out_data_reg.row;
    assign results.red          = out_data_reg.red;
    assign results.green        = out_data_reg.green;
    assign results.blue         = out_data_reg.blue;
    assign results.last_pixel   = out_data_reg.last_pixel;
    assign results.hdr_width    = out_data_reg.hdr_width;
    assign results.hdr_height   = out_data_reg.hdr_height;

    // Skid register fills only behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    // Last-pixel flag only on a pixel of row 0, the last decoded row
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_pixel) |->
            (results.result_kind == KIND_PIXEL && results.row == 12'd0))
        else $error("last pixel flag on a non-final result");

    // Pixel phase is only entered with a checked, nonzero height and width
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (stored_height_reg != '0 && stored_width_reg != '0))
        else $error("pixel phase with zero image dimension");

endmodule

`default_nettype wire
